### sv/stk_rd_pkg.sv
// ============================================================================
// stk_rd_pkg
// Shared constants and types for the response deframer.
// ============================================================================
package stk_rd_pkg;

  localparam logic [7:0] StartByte = 8'h1B;
  localparam logic [7:0] TokenByte = 8'h0E;
  localparam logic [7:0] SeqMax    = 8'hFF;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_ABANDON = 2'd2,
    KIND_NONE    = 2'd3
  } in_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SEQ       = 3'd1,
    ST_TOKEN     = 3'd2,
    ST_COMMAND   = 3'd3,
    ST_DEVICE    = 3'd4,
    ST_SHORT     = 3'd5,
    ST_CHECKSUM  = 3'd6,
    ST_RESERVED  = 3'd7
  } frame_status_e;

  typedef enum logic [0:0] {
    REG_COMMAND  = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic          last;
    logic [7:0]    payload_byte;
    frame_status_e frame_status;
    logic [15:0]   payload_length;
    logic [7:0]    sequence_now;
  } result_t;

endpackage

### sv/stk_response_deframer.sv
// ============================================================================
// stk_response_deframer
// Parses response frames from a serial byte stream, forwards payload bytes
// and reports one status word per finished or rejected frame.
// ============================================================================
//  Channel   | Direction | Payload
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata: rx_byte; tuser: kind
//  m_axis    | out       | tdata: payload_byte, frame_status, payload_length,
//            |           |        sequence_now; tlast: frame end
//  apb       | in        | expected_command at 0x0, payload_capacity at 0x4
//
//  Each word is parsed in the cycle it is accepted; its result reaches m_axis
//  via the output register. One word per cycle is sustained if m_axis drains.
//  An output register plus a one-entry skid buffer separates the two sides;
//  s_axis_tready falls only while the skid buffer is full.
//  Reset returns the parser to hunting with sequence number zero.
module stk_response_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic [1:0]                    s_axis_tuser,  // [1:0] kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [10:8] frame_status, [26:11] payload_length,
  // [34:27] sequence_now, [39:35] zero
  output logic [stk_rd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stk_rd_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import stk_rd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SEQ    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_TOKEN  = 3'd4,
    PH_BODY   = 3'd5,
    PH_CHECK  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] blen_q, blen_d;
  logic [15:0] bidx_q, bidx_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  cmd_q;
  logic [15:0] cap_q;

  result_t     res;
  logic        res_vld;
  result_t     out_q, skid_q;
  logic        out_vld_q, skid_vld_q;

  logic        acc;
  logic        out_free;
  logic        cfg_wr;
  in_kind_e    kind;
  logic [7:0]  x;
  logic [7:0]  xor_new;
  logic [15:0] blen_new;
  logic [15:0] bidx_inc;
  logic [15:0] pay_idx;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;
  assign s_axis_tready = !skid_vld_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {5'd0, out_q.sequence_now, out_q.payload_length,
                          out_q.frame_status, out_q.payload_byte};

  always_comb begin
    case (reg_index_e'(paddr[2]))
      REG_COMMAND:  prdata = {24'd0, cmd_q};
      REG_CAPACITY: prdata = {16'd0, cap_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign kind     = in_kind_e'(s_axis_tuser);
  assign x        = s_axis_tdata;
  assign xor_new  = xor_q ^ x;
  assign blen_new = {blen_q[15:8], x};
  assign bidx_inc = bidx_q + 16'd1;
  assign pay_idx  = bidx_q - 16'd2;

  always_comb begin
    phase_d = phase_q;
    seq_d   = seq_q;
    blen_d  = blen_q;
    bidx_d  = bidx_q;
    xor_d   = xor_q;
    res_vld = 1'b0;
    res     = '{last: 1'b1, payload_byte: 8'd0, frame_status: ST_OK,
                payload_length: 16'd0, sequence_now: seq_q};
    case (kind)
      KIND_CLEAR: begin
        seq_d   = 8'd0;
        phase_d = PH_HUNT;
      end
      KIND_ABANDON: begin
        phase_d = PH_HUNT;
      end
      KIND_BYTE: begin
        case (phase_q)
          PH_SEQ: begin
            xor_d = xor_new;
            if (x != seq_q) begin
              res_vld           = 1'b1;
              res.frame_status  = ST_SEQ;
              phase_d           = PH_HUNT;
            end else begin
              phase_d = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            xor_d   = xor_new;
            blen_d  = {x, 8'd0};
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            xor_d  = xor_new;
            blen_d = blen_new;
            if (blen_new < 16'd2) begin
              res_vld          = 1'b1;
              res.frame_status = ST_SHORT;
              phase_d          = PH_HUNT;
            end else begin
              phase_d = PH_TOKEN;
            end
          end
          PH_TOKEN: begin
            xor_d = xor_new;
            if (x != TokenByte) begin
              res_vld            = 1'b1;
              res.frame_status   = ST_TOKEN;
              res.payload_length = blen_q - 16'd2;
              phase_d            = PH_HUNT;
            end else begin
              bidx_d  = 16'd0;
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            xor_d = xor_new;
            if (bidx_q == 16'd0 && x != cmd_q) begin
              res_vld            = 1'b1;
              res.frame_status   = ST_COMMAND;
              res.payload_length = blen_q - 16'd2;
              phase_d            = PH_HUNT;
            end else if (bidx_q == 16'd1 && x != 8'd0) begin
              res_vld            = 1'b1;
              res.frame_status   = ST_DEVICE;
              res.payload_length = blen_q - 16'd2;
              phase_d            = PH_HUNT;
            end else begin
              if (bidx_q > 16'd1 && pay_idx < cap_q) begin
                res_vld          = 1'b1;
                res.last         = 1'b0;
                res.payload_byte = x;
              end
              bidx_d = bidx_inc;
              if (bidx_inc >= blen_q) begin
                phase_d = PH_CHECK;
              end
            end
          end
          PH_CHECK: begin
            res_vld            = 1'b1;
            res.payload_length = blen_q - 16'd2;
            phase_d            = PH_HUNT;
            if (x == xor_q) begin
              seq_d            = seq_q + 8'd1;
              res.sequence_now = seq_q + 8'd1;
            end else begin
              res.frame_status = ST_CHECKSUM;
            end
          end
          default: begin
            if (x == StartByte) begin
              xor_d   = x;
              blen_d  = 16'd0;
              bidx_d  = 16'd0;
              phase_d = PH_SEQ;
            end else begin
              phase_d = PH_HUNT;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      seq_q      <= 8'd0;
      blen_q     <= 16'd0;
      bidx_q     <= 16'd0;
      xor_q      <= 8'd0;
      cmd_q      <= 8'd0;
      cap_q      <= 16'd1024;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
      out_q      <= '0;
      skid_q     <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_index_e'(paddr[2]))
          REG_COMMAND:  cmd_q <= pwdata[7:0];
          REG_CAPACITY: cap_q <= pwdata[15:0];
          default: begin
          end
        endcase
      end
      if (acc) begin
        phase_q <= phase_d;
        seq_q   <= seq_d;
        blen_q  <= blen_d;
        bidx_q  <= bidx_d;
        xor_q   <= xor_d;
      end
      if (out_free) begin
        if (skid_vld_q) begin
          out_q      <= skid_q;
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_q     <= res;
          out_vld_q <= acc && res_vld;
        end
      end else if (acc && res_vld) begin
        skid_q     <= res;
        skid_vld_q <= 1'b1;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid buffer full while output register empty");

  a_seq_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res_vld && res.last && res.frame_status == ST_OK)
      |=> seq_q == $past(seq_q) + 8'd1)
    else $error("sequence number did not advance after a good frame");

  a_payload_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res_vld && !res.last) |-> phase_q == PH_BODY)
    else $error("payload word produced outside the frame body");

  a_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res_vld && res.last) |=> phase_q == PH_HUNT)
    else $error("parser not hunting after a frame end");

endmodule
